FILE: src/fdip_pkg.sv
// ----------------------------------------------------------------------------
// fdip_pkg
// Shared sizes and result codes for the find-duplicate-in-place unit.
// ----------------------------------------------------------------------------
package fdip_pkg;

   localparam int MAX_LEN  = 1024;
   localparam int ADDR_W   = $clog2(MAX_LEN);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int DUP_W    = 10;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_DUP     = 2'd0;
   localparam status_type ST_NODUP   = 2'd1;
   localparam status_type ST_INVALID = 2'd2;

endpackage

FILE: src/fdip_if.sv
// ----------------------------------------------------------------------------
// fdip request / response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fdip_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fdip_pkg::VALUE_W-1:0]  value;
   logic                                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface fdip_rsp_if;
   logic                         valid;
   logic                         ready;
   fdip_pkg::status_type         status;
   logic [fdip_pkg::DUP_W-1:0]   dup_value;

   modport source (output valid, output status, output dup_value, input ready);
   modport sink   (input valid, input status, input dup_value, output ready);
endinterface

FILE: src/fdip_ram.sv
// ----------------------------------------------------------------------------
// fdip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/find_duplicate_in_place_unit.sv
// ----------------------------------------------------------------------------
// find_duplicate_in_place_unit
// Loads an array word by word, then finds a duplicate by index-swap placement.
// ----------------------------------------------------------------------------
// Words on req are array elements; the word with last set closes the array and
// yields exactly one rsp word (status, dup_value); other words yield nothing.
// Loading takes in one word per cycle. After the closing word the sequencer works
// out of one element RAM (one write and one registered read port): it starts the
// first read at slot 0, runs a range check pass over all len elements, then the
// swap walk visits each index, swaps, and settles each index that needed swaps.
// The RAM port is what paces these steps. req is not ready from the closing
// word until its rsp word is taken.
// A negative or too-large element, or an array longer than MAX_LEN, gives
// status invalid without a walk.
// ----------------------------------------------------------------------------
module find_duplicate_in_place_unit (
   input  logic        clock,
   input  logic        reset,
   fdip_req_if.sink    req,
   fdip_rsp_if.source  rsp
);

   localparam int ADDR_W = fdip_pkg::ADDR_W;
   localparam int CNT_W  = fdip_pkg::CNT_W;

   // sequencer states
   localparam logic [2:0] S_LOAD = 3'd0;  // taking words
   localparam logic [2:0] S_CHK  = 3'd1;  // range check, one element a cycle
   localparam logic [2:0] S_WI   = 3'd2;  // element at idx arrives
   localparam logic [2:0] S_WV   = 3'd3;  // element at slot cur arrives
   localparam logic [2:0] S_FIN  = 3'd4;  // idx gets its own value written
   localparam logic [2:0] S_OUT  = 3'd5;  // result waiting on rsp
   localparam logic [2:0] S_RD0  = 3'd6;  // closing word is in the RAM, read slot 0

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(fdip_pkg::MAX_LEN);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       range_err_ff, range_err_in;
   logic [CNT_W-1:0]           len_ff, len_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic [ADDR_W-1:0]          cur_ff, cur_in;
   fdip_pkg::status_type       status_ff, status_in;
   logic [fdip_pkg::DUP_W-1:0] dup_ff, dup_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, wr_data, rd_addr, rd_data;

   logic              in_fire, bad_value, idx_is_end;
   logic [CNT_W-1:0]  count_next;

   fdip_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (fdip_pkg::MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req.ready     = (state_ff == S_LOAD);
   assign rsp.valid     = (state_ff == S_OUT);
   assign rsp.status    = status_ff;
   assign rsp.dup_value = dup_ff;

   assign in_fire = req.valid && req.ready;
   // negative, or not below MAX_LEN
   assign bad_value = req.value[fdip_pkg::VALUE_W-1] ||
                      (req.value[fdip_pkg::VALUE_W-2:0] >=
                       (fdip_pkg::VALUE_W-1)'(fdip_pkg::MAX_LEN));
   // count saturates one past MAX_LEN
   assign count_next = (count_ff <= MAX_CNT) ? count_ff + ONE_CNT : count_ff;
   assign idx_is_end = ({1'b0, idx_ff} == len_ff - ONE_CNT);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      range_err_in = range_err_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      dup_in       = dup_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req.value[ADDR_W-1:0];
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (in_fire) begin
               if (bad_value) begin
                  range_err_in = 1'b1;
               end else if (count_ff < MAX_CNT) begin
                  wr_en = 1'b1;
               end
               count_in = count_next;
               if (req.last) begin
                  count_in     = '0;
                  range_err_in = 1'b0;
                  len_in       = count_next;
                  dup_in       = '0;
                  if (bad_value || range_err_ff || count_next > MAX_CNT) begin
                     status_in = fdip_pkg::ST_INVALID;
                     state_in  = S_OUT;
                  end else begin
                     // closing word may land in slot 0 this cycle
                     state_in = S_RD0;
                  end
               end
            end
         end
         S_RD0: begin
            idx_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_CHK;
         end
         S_CHK: begin
            if ({1'b0, rd_data} >= len_ff) begin
               status_in = fdip_pkg::ST_INVALID;
               state_in  = S_OUT;
            end else if (idx_is_end) begin
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_WI;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               rd_en    = 1'b1;
               rd_addr  = idx_ff + ADDR_W'(1);
            end
         end
         S_WI: begin
            cur_in = rd_data;
            if (rd_data == idx_ff) begin
               if (idx_is_end) begin
                  status_in = fdip_pkg::ST_NODUP;
                  state_in  = S_OUT;
               end else begin
                  idx_in  = idx_ff + ADDR_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + ADDR_W'(1);
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = rd_data;
               state_in = S_WV;
            end
         end
         S_WV: begin
            // rd_data is the element sitting in slot cur
            if (rd_data == cur_ff) begin
               status_in = fdip_pkg::ST_DUP;
               dup_in    = cur_ff;
               state_in  = S_OUT;
            end else begin
               // slot idx is held in cur_ff; written back once settled
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = cur_ff;
               cur_in  = rd_data;
               if (rd_data == idx_ff) begin
                  state_in = S_FIN;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rd_data;
               end
            end
         end
         S_FIN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = idx_ff;
            if (idx_is_end) begin
               status_in = fdip_pkg::ST_NODUP;
               state_in  = S_OUT;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               rd_en    = 1'b1;
               rd_addr  = idx_ff + ADDR_W'(1);
               state_in = S_WI;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         range_err_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         range_err_ff <= range_err_in;
      end
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      dup_ff    <= dup_in;
   end

endmodule
